/* hw/rtl/ss_pkg.sv */
`default_nettype none

package ss_pkg;

  // Element and result field widths
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned MOVE_W       = 16;
  localparam int unsigned OUT_TDATA_W  = DATA_W + MOVE_W;

  // Default store depth
  localparam int unsigned MAX_ELEMENTS_DEF = 64;

  // Saturating move counter step
  function automatic logic [MOVE_W-1:0] move_inc(input logic [MOVE_W-1:0] cnt);
    logic [MOVE_W-1:0] res;
    res = (cnt == {MOVE_W{1'b1}}) ? cnt : cnt + MOVE_W'(1);
    return res;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ss_ram.sv */
`default_nettype none

module ss_ram
  import ss_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_ELEMENTS_DEF,
  parameter int unsigned AW    = $clog2(MAX_ELEMENTS_DEF)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Hold read data until the next read is issued
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hw/rtl/shell_sort_engine.sv */
// Flow: load beats are written to the store as they arrive. After the beat marked last the sort runs in place:
//   each insertion reads, holds and compares, shifting larger elements up until the held one is placed.
// Output: each beat is read, then loaded into the output register, unless stalled.
// Throughput: one set at a time, limited by the read-compare-write loop on the store,
//   which has one read port and one write port.
// Reset: synchronous, active low; clears the FSM, counters and output valid, not the store.
`default_nettype none

module shell_sort_engine
  import ss_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [DATA_W-1:0]      in_tdata,   // [31:0] value
  input  wire logic                   in_tlast,   // last
  // Result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // [31:0] sorted_value, [47:32] move_count
  output logic                        out_tlast,  // last_out
  output logic                        out_tuser   // overflow
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [2:0] {
    S_LOAD,   // take input beats into the store
    S_GAP,    // start a pass, or finish when the gap reaches zero
    S_RDI,    // read element i (the one to insert), or end the pass
    S_HOLD,   // capture it, read element j-gap
    S_CMP,    // compare and shift, or place
    S_PLACE,  // place held element after the last shift
    S_ORD,    // read next sorted element
    S_OWAIT   // move it into the output register
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              drop_r, drop_nxt;
  logic [MOVE_W-1:0] move_r, move_nxt;
  logic [CW-1:0]     gap_r, gap_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [DATA_W-1:0] held_r, held_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;
  logic [MOVE_W-1:0] out_move_r, out_move_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  // Store port
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  ss_ram #(
    .DEPTH (MAX_ELEMENTS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_move_r, out_data_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  // Sequencer. Reads and writes in the same cycle never hit the same entry:
  // a shift writes j and reads j-2*gap, a placement writes j <= i and the next
  // read is i+1, so no forwarding is needed around the store.
  always_comb begin
    logic [CW-1:0] j_dec;
    logic [CW-1:0] j_dec2;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    move_nxt      = move_r;
    gap_nxt       = gap_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_move_nxt  = out_move_r;
    out_ovf_nxt   = out_ovf_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    j_dec         = j_r - gap_r;
    j_dec2        = j_dec - gap_r;

    case (state_r)
      S_LOAD: begin
        if (in_tvalid) begin
          // Store the beat, or drop it and flag once the store is full
          if (cnt_r < CW'(MAX_ELEMENTS)) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_r[AW-1:0];
            mem_wdata = in_tdata;
            cnt_nxt   = cnt_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            gap_nxt   = cnt_nxt >> 1;
            state_nxt = S_GAP;
          end
        end
      end
      S_GAP: begin
        if (gap_r == '0) begin
          k_nxt     = '0;
          state_nxt = S_ORD;
        end else begin
          i_nxt     = gap_r;
          state_nxt = S_RDI;
        end
      end
      S_RDI: begin
        if (i_r >= cnt_r) begin
          gap_nxt   = gap_r >> 1;
          state_nxt = S_GAP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = i_r[AW-1:0];
          j_nxt     = i_r;
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        // j equals i here, and i >= gap, so j-gap is always in range
        held_nxt  = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = j_dec[AW-1:0];
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if ($signed(mem_rdata) > $signed(held_r)) begin
          // Shift the larger element up one gap
          mem_we    = 1'b1;
          mem_waddr = j_r[AW-1:0];
          mem_wdata = mem_rdata;
          move_nxt  = move_inc(move_r);
          j_nxt     = j_dec;
          if (j_dec >= gap_r) begin
            mem_re    = 1'b1;
            mem_raddr = j_dec2[AW-1:0];
            state_nxt = S_CMP;
          end else begin
            state_nxt = S_PLACE;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = j_r[AW-1:0];
          mem_wdata = held_r;
          move_nxt  = move_inc(move_r);
          i_nxt     = i_r + CW'(1);
          state_nxt = S_RDI;
        end
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[AW-1:0];
        mem_wdata = held_r;
        move_nxt  = move_inc(move_r);
        i_nxt     = i_r + CW'(1);
        state_nxt = S_RDI;
      end
      S_ORD: begin
        mem_re    = 1'b1;
        mem_raddr = k_r[AW-1:0];
        state_nxt = S_OWAIT;
      end
      S_OWAIT: begin
        // Advance only when the output register is free or being drained
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mem_rdata;
          out_last_nxt  = (k_r == cnt_r - CW'(1));
          out_move_nxt  = move_r;
          out_ovf_nxt   = drop_r;
          if (k_r == cnt_r - CW'(1)) begin
            // Set done: clear bookkeeping, take the next set while the last beat waits
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            move_nxt  = '0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = S_ORD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      move_r      <= '0;
      gap_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      move_r      <= move_nxt;
      gap_r       <= gap_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      held_r      <= held_nxt;
      out_data_r  <= out_data_nxt;
      out_last_r  <= out_last_nxt;
      out_move_r  <= out_move_nxt;
      out_ovf_r   <= out_ovf_nxt;
    end
  end

  // Count never passes the store depth
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CW'(MAX_ELEMENTS))
    else $error("element count beyond store depth");

  // Gap never exceeds the stored count
  assert property (@(posedge clk) disable iff (!rst_n) gap_r <= cnt_r)
    else $error("gap larger than element count");

  // Compare step always works on a valid slot pair
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (j_r >= gap_r && j_r < cnt_r && gap_r != '0))
    else $error("compare index out of range");

  // Move counter is cleared between sets
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> (move_r == '0))
    else $error("move counter not cleared while loading");

  // Store writes outside loading stay inside the current set
  assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != S_LOAD) |-> (CW'(mem_waddr) < cnt_r))
    else $error("sort write outside current set");

endmodule

`default_nettype wire
